FILE: hw/rtl/ftws_pkg.sv
// Package for the frame-time window statistics core.
// Shared widths, reset values, register indexes and cell types.
// No dependencies.
package ftws_pkg;

    localparam int DATA_W         = 24;
    localparam int CNT_W          = 32;
    localparam int RATE_W         = 30;
    localparam int PERMILLE_W     = 10;
    localparam int DEN_W          = 24;
    localparam int CFG_IDX_W      = 1;
    localparam int WINDOW_DEFAULT = 128;

    localparam logic [DATA_W-1:0]     THRESH_RESET   = DATA_W'(250000);
    localparam logic [PERMILLE_W-1:0] PERMILLE_RESET = PERMILLE_W'(990);
    localparam logic [PERMILLE_W-1:0] PERMILLE_MAX   = PERMILLE_W'(1000);
    localparam int                    RANK_BIAS      = 999;
    localparam int                    RANK_DIVISOR   = 1000;
    localparam int                    RATE_NUM       = 1000000000;

    // x / 1000 as (x * ceil(2^30 / 1000)) >> 30, exact for x below 2^22
    localparam int                      RANK_RECIP_W = 21;
    localparam logic [RANK_RECIP_W-1:0] RANK_RECIP   = RANK_RECIP_W'(1073742);
    localparam int                      RANK_SHIFT   = 30;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_THRESH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERMILLE     = 1'b1;

    // word that circulates around the ring of cells
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
    } trav_t;

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic insert;     // shift a new sample into the chain
        logic load_rank;  // load circulating copy, clear rank counters
        logic count;      // compare circulating word against own sample
        logic load_hit;   // load circulating copy tagged with rank hit
        logic shift;      // rotate circulating words by one cell
    } cell_ctrl_t;

endpackage

FILE: hw/rtl/ftws_cell.sv
// One window cell: holds one sample, a circulating word and rank counters.
// Depends on ftws_pkg.
module ftws_cell #(
    parameter int CW = 8
) (
    input  logic                       clk,
    input  ftws_pkg::cell_ctrl_t       ctrl,
    input  logic                       live,
    input  logic [CW-1:0]              rank_k,
    input  logic [ftws_pkg::DATA_W-1:0] sample_in,
    output logic [ftws_pkg::DATA_W-1:0] sample_out,
    input  ftws_pkg::trav_t            trav_in,
    output ftws_pkg::trav_t            trav_out
);

    logic [ftws_pkg::DATA_W-1:0] data_reg;
    ftws_pkg::trav_t             trav_reg;
    logic [CW-1:0]               below_reg;
    logic [CW-1:0]               upto_reg;
    logic                        hit;

    // this cell holds the requested rank
    assign hit = live && (below_reg <= rank_k) && (rank_k < upto_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.insert)
        begin
            data_reg <= sample_in;
        end

        // rank counters
        if (ctrl.load_rank)
        begin
            below_reg <= '0;
            upto_reg  <= '0;
        end
        else if (ctrl.count && trav_reg.valid)
        begin
            if (trav_reg.data < data_reg)
            begin
                below_reg <= below_reg + CW'(1);
            end
            if (trav_reg.data <= data_reg)
            begin
                upto_reg <= upto_reg + CW'(1);
            end
        end

        // circulating word
        if (ctrl.load_rank)
        begin
            trav_reg <= '{valid: live, data: data_reg};
        end
        else if (ctrl.load_hit)
        begin
            trav_reg <= '{valid: hit, data: data_reg};
        end
        else if (ctrl.shift)
        begin
            trav_reg <= trav_in;
        end
    end

    assign sample_out = data_reg;
    assign trav_out   = trav_reg;

endmodule

FILE: hw/rtl/ftws_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module ftws_div #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DEN_W:0]    rem_sh;
    logic              ge;
    logic [DEN_W:0]    rem_sub;

    // trial subtract
    assign rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // pulse on the last quotient bit
            done_reg <= busy_reg && !start && (cnt_reg == STEP_W'(NUM_W - 1));
            if (start)
            begin
                quo_reg  <= num;
                rem_reg  <= '0;
                den_reg  <= den;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], ge};
                cnt_reg <= cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

FILE: hw/rtl/frame_time_window_stats_core.sv
// Top level of the frame-time window statistics core.
// Depends on ftws_pkg, ftws_cell and ftws_div.
//
//   channel  direction  handshake            contents
//   in       to core    in_valid / in_stall  frame_time_us, sim_steps_dropped
//   out      from core  out_valid/out_stall  eleven statistics fields
//   cfg      to core    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One event passes through the rank states S_RANK_NUM and S_RANK_PICK, two
// trips of the circulating word around the cell ring (rank count, then rank
// pick-up) and two runs of the bit-serial divider (mean, rate). The result
// is loaded into the output register in S_OUT; in_stall is high until then.
// A held result only delays the final load of the next event. Reset is
// asynchronous; the sample cells need none, the fill count masks them.
module frame_time_window_stats_core #(
    parameter int WINDOW = ftws_pkg::WINDOW_DEFAULT,
    parameter int FW     = $clog2(WINDOW + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // events
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [ftws_pkg::DATA_W:0] frame_time_us,
    input  logic                             sim_steps_dropped,
    // results
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ftws_pkg::DATA_W-1:0]      last_us,
    output logic [ftws_pkg::DATA_W-1:0]      mean_us,
    output logic [ftws_pkg::DATA_W-1:0]      min_us,
    output logic [ftws_pkg::DATA_W-1:0]      max_us,
    output logic [ftws_pkg::DATA_W-1:0]      percentile_us,
    output logic [ftws_pkg::DATA_W-1:0]      worst_us,
    output logic [ftws_pkg::CNT_W-1:0]       frames_seen,
    output logic [ftws_pkg::CNT_W-1:0]       stall_count,
    output logic [ftws_pkg::CNT_W-1:0]       dropped_step_count,
    output logic [FW-1:0]                    window_fill,
    output logic [ftws_pkg::RATE_W-1:0]      rate_milli_fps,
    // configuration
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ftws_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ftws_pkg::DATA_W-1:0]      cfg_data
);

    localparam int DW      = ftws_pkg::DATA_W;
    localparam int SW      = $clog2(WINDOW);
    localparam int SUM_W   = DW + $clog2(WINDOW);
    localparam int DIV_W   = (SUM_W > ftws_pkg::RATE_W) ? SUM_W : ftws_pkg::RATE_W;
    localparam int PROD_W  = ftws_pkg::PERMILLE_W + FW;
    localparam int RPROD_W = PROD_W + 1 + ftws_pkg::RANK_RECIP_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RANK_NUM,
        S_RANK_PICK,
        S_PASS_RANK,
        S_HIT_LOAD,
        S_PASS_HIT,
        S_MEAN_DIV,
        S_RATE_DIV,
        S_OUT
    } state_t;

    state_t                           state_reg;
    logic [SW-1:0]                    step_reg;
    logic [FW-1:0]                    fill_reg;
    logic [DW-1:0]                    worst_reg;
    logic [ftws_pkg::CNT_W-1:0]       frame_reg;
    logic [ftws_pkg::CNT_W-1:0]       stall_reg;
    logic [ftws_pkg::CNT_W-1:0]       drop_reg;
    logic [DW-1:0]                    thresh_reg;
    logic [ftws_pkg::PERMILLE_W-1:0]  permille_reg;
    logic [FW-1:0]                    k_reg;
    logic [PROD_W:0]                  rank_num_reg;
    logic [SUM_W-1:0]                 sum_reg;
    logic [DW-1:0]                    min_reg;
    logic [DW-1:0]                    max_reg;
    logic [DW-1:0]                    pct_reg;
    logic [DW-1:0]                    mean_reg;
    logic                             div_start_reg;

    logic                             out_valid_reg;
    logic [DW-1:0]                    last_out_reg;
    logic [DW-1:0]                    mean_out_reg;
    logic [DW-1:0]                    min_out_reg;
    logic [DW-1:0]                    max_out_reg;
    logic [DW-1:0]                    pct_out_reg;
    logic [DW-1:0]                    worst_out_reg;
    logic [ftws_pkg::CNT_W-1:0]       frame_out_reg;
    logic [ftws_pkg::CNT_W-1:0]       stall_out_reg;
    logic [ftws_pkg::CNT_W-1:0]       drop_out_reg;
    logic [FW-1:0]                    fill_out_reg;
    logic [ftws_pkg::RATE_W-1:0]      rate_out_reg;

    logic                             accept;
    logic                             negative;
    logic [DW-1:0]                    us;
    logic                             store;
    ftws_pkg::cell_ctrl_t             ctrl;
    logic                             last_step;
    logic [ftws_pkg::PERMILLE_W-1:0]  p_clamped;
    logic [PROD_W:0]                  rank_num;
    logic [RPROD_W-1:0]               rank_prod;
    logic [DIV_W-1:0]                 div_num;
    logic [ftws_pkg::DEN_W-1:0]       div_den;
    logic                             div_start_next;
    logic                             div_done;
    logic [DIV_W-1:0]                 div_quot;
    logic [FW-1:0]                    rank;
    logic [FW-1:0]                    rank_k;
    logic                             empty;
    logic                             out_load;
    ftws_pkg::trav_t                  head;

    logic [DW-1:0]                    cell_data [WINDOW];
    ftws_pkg::trav_t                  cell_trav [WINDOW];

    // input decode
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign negative = frame_time_us[DW];
    assign us       = frame_time_us[DW-1:0];
    assign store    = !negative && (us < thresh_reg);
    assign in_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // cell commands
    always_comb
    begin
        ctrl.insert    = accept && store;
        ctrl.load_rank = (state_reg == S_RANK_PICK);
        ctrl.count     = (state_reg == S_PASS_RANK);
        ctrl.load_hit  = (state_reg == S_HIT_LOAD);
        ctrl.shift     = (state_reg == S_PASS_RANK) || (state_reg == S_PASS_HIT);
    end

    assign last_step = (step_reg == SW'(WINDOW - 1));

    // rank = ceil(p * fill / 1000), then index = rank - 1 clamped
    assign p_clamped = (permille_reg > ftws_pkg::PERMILLE_MAX) ?
                       ftws_pkg::PERMILLE_MAX : permille_reg;
    assign rank_num  = (PROD_W + 1)'(p_clamped) * (PROD_W + 1)'(fill_reg)
                       + (PROD_W + 1)'(ftws_pkg::RANK_BIAS);
    // divide by 1000 through the reciprocal
    assign rank_prod = RPROD_W'(rank_num_reg) * RPROD_W'(ftws_pkg::RANK_RECIP);
    assign rank      = rank_prod[ftws_pkg::RANK_SHIFT +: FW];
    always_comb
    begin
        rank_k = (rank == '0) ? '0 : rank - FW'(1);
        if (rank_k > fill_reg - FW'(1))
        begin
            rank_k = fill_reg - FW'(1);
        end
    end

    // divider operand select and start
    always_comb
    begin
        case (state_reg)
            S_MEAN_DIV:
            begin
                div_num = DIV_W'(sum_reg);
                div_den = ftws_pkg::DEN_W'(fill_reg);
            end
            default:
            begin
                div_num = DIV_W'(ftws_pkg::RATE_NUM);
                div_den = mean_reg;
            end
        endcase
    end

    assign div_start_next = ((state_reg == S_PASS_HIT) && last_step) ||
                            ((state_reg == S_MEAN_DIV) && div_done);

    ftws_div #(
        .NUM_W (DIV_W),
        .DEN_W (ftws_pkg::DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // chain of cells; newest sample enters cell 0, circulating words rotate
    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        logic [DW-1:0] sin;
        if (i == 0)
        begin : g_head
            assign sin = us;
        end
        else
        begin : g_body
            assign sin = cell_data[i-1];
        end

        ftws_cell #(
            .CW (FW)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .live       (FW'(i) < fill_reg),
            .rank_k     (k_reg),
            .sample_in  (sin),
            .sample_out (cell_data[i]),
            .trav_in    (cell_trav[(i + 1) % WINDOW]),
            .trav_out   (cell_trav[i])
        );
    end

    assign head     = cell_trav[0];
    assign empty    = (fill_reg == '0);
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    // sequencer, counters, accumulators and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            fill_reg      <= '0;
            worst_reg     <= '0;
            frame_reg     <= '0;
            stall_reg     <= '0;
            drop_reg      <= '0;
            thresh_reg    <= ftws_pkg::THRESH_RESET;
            permille_reg  <= ftws_pkg::PERMILLE_RESET;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= div_start_next;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    ftws_pkg::CFG_STALL_THRESH: thresh_reg   <= cfg_data;
                    ftws_pkg::CFG_PERMILLE:     permille_reg <= cfg_data[ftws_pkg::PERMILLE_W-1:0];
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (!negative)
                        begin
                            frame_reg <= frame_reg + ftws_pkg::CNT_W'(1);
                            if (sim_steps_dropped)
                            begin
                                drop_reg <= drop_reg + ftws_pkg::CNT_W'(1);
                            end
                            if (!store)
                            begin
                                stall_reg <= stall_reg + ftws_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                if (fill_reg != FW'(WINDOW))
                                begin
                                    fill_reg <= fill_reg + FW'(1);
                                end
                                if (us > worst_reg)
                                begin
                                    worst_reg <= us;
                                end
                            end
                        end
                        state_reg <= S_RANK_NUM;
                    end
                end
                S_RANK_NUM:
                begin
                    rank_num_reg <= rank_num;
                    state_reg    <= S_RANK_PICK;
                end
                S_RANK_PICK:
                begin
                    k_reg     <= rank_k;
                    sum_reg   <= '0;
                    min_reg   <= '1;
                    max_reg   <= '0;
                    pct_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= S_PASS_RANK;
                end
                S_PASS_RANK:
                begin
                    // sum, min and max from the word passing cell 0
                    if (head.valid)
                    begin
                        sum_reg <= sum_reg + SUM_W'(head.data);
                        if (head.data < min_reg)
                        begin
                            min_reg <= head.data;
                        end
                        if (head.data > max_reg)
                        begin
                            max_reg <= head.data;
                        end
                    end
                    step_reg <= step_reg + SW'(1);
                    if (last_step)
                    begin
                        state_reg <= S_HIT_LOAD;
                    end
                end
                S_HIT_LOAD:
                begin
                    step_reg  <= '0;
                    state_reg <= S_PASS_HIT;
                end
                S_PASS_HIT:
                begin
                    if (head.valid)
                    begin
                        pct_reg <= head.data;
                    end
                    step_reg <= step_reg + SW'(1);
                    if (last_step)
                    begin
                        state_reg <= S_MEAN_DIV;
                    end
                end
                S_MEAN_DIV:
                begin
                    if (div_done)
                    begin
                        mean_reg  <= div_quot[DW-1:0];
                        state_reg <= S_RATE_DIV;
                    end
                end
                S_RATE_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        last_out_reg  <= empty ? '0 : cell_data[0];
                        mean_out_reg  <= empty ? '0 : mean_reg;
                        min_out_reg   <= empty ? '0 : min_reg;
                        max_out_reg   <= empty ? '0 : max_reg;
                        pct_out_reg   <= empty ? '0 : pct_reg;
                        worst_out_reg <= worst_reg;
                        frame_out_reg <= frame_reg;
                        stall_out_reg <= stall_reg;
                        drop_out_reg  <= drop_reg;
                        fill_out_reg  <= fill_reg;
                        rate_out_reg  <= (empty || mean_reg == '0) ?
                                         '0 : div_quot[ftws_pkg::RATE_W-1:0];
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid          = out_valid_reg;
    assign last_us            = last_out_reg;
    assign mean_us            = mean_out_reg;
    assign min_us             = min_out_reg;
    assign max_us             = max_out_reg;
    assign percentile_us      = pct_out_reg;
    assign worst_us           = worst_out_reg;
    assign frames_seen        = frame_out_reg;
    assign stall_count        = stall_out_reg;
    assign dropped_step_count = drop_out_reg;
    assign window_fill        = fill_out_reg;
    assign rate_milli_fps     = rate_out_reg;

`ifndef SYNTHESIS
    // fill never exceeds the window
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(WINDOW))
        else $error("fill count above window size");

    // fill only grows, one step at a time
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |-> (fill_reg == $past(fill_reg) + FW'(1)))
        else $error("fill count jumped");

    // percentile lies inside the min/max range, mean does not exceed max
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (min_out_reg <= pct_out_reg) && (pct_out_reg <= max_out_reg)
                          && (mean_out_reg <= max_out_reg))
        else $error("statistics out of order");

    // an empty window reports zero last, max and rate figures
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fill_out_reg == '0) |->
        (last_out_reg == '0) && (max_out_reg == '0) && (rate_out_reg == '0))
        else $error("nonzero figure with empty window");
`endif

endmodule
